>>> hw/rtl/mmp_pkg.sv
// Shared types, constants and the channel-wise pooling function for the
// mixed max/min 2x2 pooling block. No dependencies.
package mmp_pkg;

  localparam int CH_W = 8;
  localparam int PX_W = 4 * CH_W;
  localparam int CNT_W = 6;
  localparam int IDX_W = 9;
  localparam int MAP_WIDTH_DEF = 40;
  localparam int MAP_HEIGHT_DEF = 40;

  // Gate channel min-pooling starts from this value
  localparam logic [CH_W-1:0] GATE_START = 8'hFF;

  // Packed pixel: obstacle 7:0, range 15:8, uncertainty 23:16, gate 31:24
  typedef logic [PX_W-1:0] px_t;

  // Per-cell information that travels with an emitting item
  typedef struct packed {
    px_t              pair;
    logic [IDX_W-1:0] cell_index;
    logic             frame_last;
  } issue_t;

  // Max over the first three channels, min over the gate channel
  function automatic px_t pool_merge(input px_t a, input px_t b);
    px_t r;
    logic [CH_W-1:0] x;
    logic [CH_W-1:0] y;
    r = '0;
    for (int k = 0; k < 4; k++) begin
      x = a[k*CH_W +: CH_W];
      y = b[k*CH_W +: CH_W];
      if (k == 3) begin
        r[k*CH_W +: CH_W] = (x < y) ? x : y;
      end else begin
        r[k*CH_W +: CH_W] = (x > y) ? x : y;
      end
    end
    return r;
  endfunction

endpackage

>>> hw/rtl/mmp_front.sv
// Position counters, horizontal pair pooling and line-store access issue.
// Depends on mmp_pkg.
module mmp_front #(
  parameter int MAP_WIDTH = mmp_pkg::MAP_WIDTH_DEF,
  parameter int MAP_HEIGHT = mmp_pkg::MAP_HEIGHT_DEF,
  parameter int ADDR_W = 5
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    accept,
  input  logic [7:0]              obstacle_value,
  input  logic [7:0]              range_value,
  input  logic [7:0]              uncertainty_value,
  input  logic [7:0]              gate_value,
  input  logic                    frame_start,
  output logic                    mem_wr,
  output logic                    mem_rd,
  output logic [ADDR_W-1:0]       mem_addr,
  output mmp_pkg::issue_t         issue
);
  import mmp_pkg::*;

  localparam int CTRL_W = MAP_WIDTH / 2;
  localparam int CTRL_H = MAP_HEIGHT / 2;

  logic [CNT_W-1:0]   column_count;
  logic [CNT_W-1:0]   row_count;
  px_t                pair_partial;
  logic [CNT_W-1:0]   col;
  logic [CNT_W-1:0]   row;
  logic [CNT_W-2:0]   cx;
  logic [CNT_W-2:0]   cy;
  logic [CNT_W-1:0]   col_inc;
  logic [CNT_W-1:0]   row_inc;
  logic [CNT_W-1:0]   column_count_next;
  logic [CNT_W-1:0]   row_count_next;
  logic               in_block;
  px_t                px;
  logic [IDX_W+1:0]   cell_full;

  // Current position; frame start forces the origin
  assign col = frame_start ? '0 : column_count;
  assign row = frame_start ? '0 : row_count;
  assign cx  = col[CNT_W-1:1];
  assign cy  = row[CNT_W-1:1];
  assign in_block = (CNT_W'(cx) < CNT_W'(CTRL_W)) && (CNT_W'(cy) < CNT_W'(CTRL_H));

  assign px = {gate_value, uncertainty_value, range_value, obstacle_value};

  // Raster counter advance with wrap at map edges
  always_comb begin
    col_inc = col + CNT_W'(1);
    row_inc = row + CNT_W'(1);
    column_count_next = col_inc;
    row_count_next = row;
    if (col_inc >= CNT_W'(MAP_WIDTH)) begin
      column_count_next = '0;
      row_count_next = (row_inc >= CNT_W'(MAP_HEIGHT)) ? '0 : row_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count <= '0;
      pair_partial <= '0;
    end else if (accept) begin
      column_count <= column_count_next;
      row_count <= row_count_next;
      if (in_block && !col[0]) begin
        pair_partial <= px;
      end
    end
  end

  // Even rows park the pair, odd rows fetch the parked pair
  assign mem_wr   = accept && in_block && col[0] && !row[0];
  assign mem_rd   = accept && in_block && col[0] && row[0];
  assign mem_addr = cx[ADDR_W-1:0];

  assign cell_full = (IDX_W+2)'(cy) * (IDX_W+2)'(CTRL_W) + (IDX_W+2)'(cx);

  always_comb begin
    issue.pair       = pool_merge(pair_partial, px);
    issue.cell_index = cell_full[IDX_W-1:0];
    issue.frame_last = (CNT_W'(cx) == CNT_W'(CTRL_W - 1)) &&
                       (CNT_W'(cy) == CNT_W'(CTRL_H - 1));
  end

endmodule

>>> hw/rtl/mmp_line_buf.sv
// One-row line store of pair results, one access per cycle, registered read.
// Depends on mmp_pkg.
module mmp_line_buf #(
  parameter int DEPTH = mmp_pkg::MAP_WIDTH_DEF / 2,
  parameter int ADDR_W = 5
) (
  input  logic              clk,
  input  logic              wr,
  input  logic              rd,
  input  logic [ADDR_W-1:0] addr,
  input  mmp_pkg::px_t      wdata,
  output mmp_pkg::px_t      rdata
);
  import mmp_pkg::*;

  px_t mem [DEPTH];

  // Contents are undefined until an even row writes them
  always_ff @(posedge clk) begin
    if (wr) begin
      mem[addr] <= wdata;
    end
  end

  // Read data holds between reads so a stalled stage keeps it
  always_ff @(posedge clk) begin
    if (rd) begin
      rdata <= mem[addr];
    end
  end

endmodule

>>> hw/rtl/mmp_back.sv
// Block merge stage and output register with the result handshake.
// Depends on mmp_pkg.
module mmp_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            load,
  input  mmp_pkg::issue_t issue,
  input  mmp_pkg::px_t    rdata,
  output logic            ready,
  output logic            cell_valid,
  input  logic            cell_stall,
  output logic [7:0]      pooled_obstacle,
  output logic [7:0]      pooled_range,
  output logic [7:0]      pooled_uncertainty,
  output logic [7:0]      pooled_gate,
  output logic [8:0]      cell_index,
  output logic            frame_last
);
  import mmp_pkg::*;

  logic   s1_valid;
  issue_t s1_info;
  logic   out_load;
  px_t    blk;
  px_t    blk_gated;

  assign out_load = !cell_valid || !cell_stall;
  assign ready    = !s1_valid || out_load;

  // Stage 1: wait for the line-store read
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (ready) begin
      s1_valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (ready && load) begin
      s1_info <= issue;
    end
  end

  // Combine parked even-row pair with the odd-row pair
  assign blk       = pool_merge(rdata, s1_info.pair);
  assign blk_gated = pool_merge(blk, {GATE_START, {(3*CH_W){1'b0}}});

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      cell_valid <= 1'b0;
    end else if (out_load) begin
      cell_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load && s1_valid) begin
      pooled_obstacle    <= blk_gated[0*CH_W +: CH_W];
      pooled_range       <= blk_gated[1*CH_W +: CH_W];
      pooled_uncertainty <= blk_gated[2*CH_W +: CH_W];
      pooled_gate        <= blk_gated[3*CH_W +: CH_W];
      cell_index         <= s1_info.cell_index;
      frame_last         <= s1_info.frame_last;
    end
  end

endmodule

>>> hw/rtl/mixed_max_min_pool_2x2_top.sv
// Top level of the mixed max/min 2x2 pooling block.
// Depends on mmp_pkg, mmp_front, mmp_line_buf and mmp_back.
//
// Streams feature-map pixels in raster order, one item per clock while
// pixel_stall is low, and emits one pooled cell for every 2x2 block (max of
// obstacle, range and uncertainty, min of gate). Each pixel touches the line
// store at most once: pixels at the odd column of an even row write their
// pair result, pixels at the odd column of an odd row read it back. A result
// passes through stage 1 (the registered line-store read) and the output
// register before it appears on the cell channel. The line store is
// MAP_WIDTH/2 entries of 32 bits and needs no clearing pass; write and read
// of the same entry are always a full row apart, so no forwarding path exists.
// pixel_stall follows cell_stall only when both pipeline stages hold results.
module mixed_max_min_pool_2x2_top #(
  parameter int MAP_WIDTH = mmp_pkg::MAP_WIDTH_DEF,
  parameter int MAP_HEIGHT = mmp_pkg::MAP_HEIGHT_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       pixel_valid,
  output logic       pixel_stall,
  input  logic [7:0] obstacle_value,
  input  logic [7:0] range_value,
  input  logic [7:0] uncertainty_value,
  input  logic [7:0] gate_value,
  input  logic       frame_start,
  output logic       cell_valid,
  input  logic       cell_stall,
  output logic [7:0] pooled_obstacle,
  output logic [7:0] pooled_range,
  output logic [7:0] pooled_uncertainty,
  output logic [7:0] pooled_gate,
  output logic [8:0] cell_index,
  output logic       frame_last
);
  import mmp_pkg::*;

  localparam int CTRL_W = MAP_WIDTH / 2;
  localparam int ADDR_W = (CTRL_W > 1) ? $clog2(CTRL_W) : 1;

  logic              accept;
  logic              ready;
  logic              mem_wr;
  logic              mem_rd;
  logic [ADDR_W-1:0] mem_addr;
  issue_t            issue;
  px_t               rdata;

  assign pixel_stall = !ready;
  assign accept      = pixel_valid && ready;

  mmp_front #(
    .MAP_WIDTH (MAP_WIDTH),
    .MAP_HEIGHT(MAP_HEIGHT),
    .ADDR_W    (ADDR_W)
  ) u_front (
    .clk              (clk),
    .rst              (rst),
    .accept           (accept),
    .obstacle_value   (obstacle_value),
    .range_value      (range_value),
    .uncertainty_value(uncertainty_value),
    .gate_value       (gate_value),
    .frame_start      (frame_start),
    .mem_wr           (mem_wr),
    .mem_rd           (mem_rd),
    .mem_addr         (mem_addr),
    .issue            (issue)
  );

  mmp_line_buf #(
    .DEPTH (CTRL_W),
    .ADDR_W(ADDR_W)
  ) u_line_buf (
    .clk  (clk),
    .wr   (mem_wr),
    .rd   (mem_rd),
    .addr (mem_addr),
    .wdata(issue.pair),
    .rdata(rdata)
  );

  mmp_back u_back (
    .clk               (clk),
    .rst               (rst),
    .load              (mem_rd),
    .issue             (issue),
    .rdata             (rdata),
    .ready             (ready),
    .cell_valid        (cell_valid),
    .cell_stall        (cell_stall),
    .pooled_obstacle   (pooled_obstacle),
    .pooled_range      (pooled_range),
    .pooled_uncertainty(pooled_uncertainty),
    .pooled_gate       (pooled_gate),
    .cell_index        (cell_index),
    .frame_last        (frame_last)
  );

endmodule
